### rtl/core/upbi_pkg.sv
package upbi_pkg;

  localparam int MaxSideDef = 64;
  localparam int ScaleDef   = 2;

  localparam int SampleW = 24;
  localparam int SideW   = 7;
  localparam int RadW    = 4;
  localparam int PosW    = 7;
  // window count is at most 31 x 31
  localparam int CntW    = 10;
  // 2*|sum| + count for a full window of extreme samples
  localparam int DivW    = 36;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BRD,
    ST_BWR,
    ST_QRD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    REG_SIDE   = 2'd0,
    REG_RADIUS = 2'd1,
    REG_FILL   = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

endpackage

### rtl/core/upsample_box_blur_integral.sv
// Upsampled box blur over a square patch, built on a summed-area table.
// Input stream: tuser[0] selects load (0) or query (1). A load writes the next
// sample of the patch in raster order. The load that completes the patch
// upsamples it by nearest neighbour and builds the summed-area table over
// n x n entries (n = SCALE * side); the input is not ready during that pass.
// A query reads four table corners, then divides by the clipped window
// count one quotient bit a cycle in the divider. A query on an incomplete
// patch or outside the image returns a status code and value 0.
// Results sit in an output register: while the receiver stalls, loads are
// still taken, and a finished query waits until the register is free.
// Reset: configuration registers return to their reset values, the load
// position and the table-ready flag clear; memory contents are undefined.
// Configuration is an APB port with pready tied high; writing patch_side
// restarts loading.
module upsample_box_blur_integral #(
  parameter int MAX_SIDE = upbi_pkg::MaxSideDef,
  parameter int SCALE    = upbi_pkg::ScaleDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sample[23:0], no_value[24], row[31:25], col[38:32], zero[39]
  input  logic [39:0] s_axis_tdata_i,
  // operation[0]
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // value[23:0], status[25:24], zero[31:26]
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import upbi_pkg::*;

  localparam int UpMax  = SCALE * MAX_SIDE;
  localparam int CW     = $clog2(UpMax);
  localparam int NW     = CW + 1;
  localparam int QW     = (NW > 8) ? NW : 8;
  localparam int SW     = $clog2(MAX_SIDE + 1);
  localparam int AW     = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int PW     = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SBW    = (SCALE > 1) ? $clog2(SCALE) : 1;
  localparam int SATW   = SampleW + 2 * CW;
  localparam int SatDep = 1 << (2 * CW);
  localparam int SrcDep = MAX_SIDE * MAX_SIDE;
  localparam int VW     = CntW + 1;

  // configuration
  logic [SideW-1:0]   side_q;
  logic [RadW-1:0]    rad_q;
  logic [SampleW-1:0] fill_q;
  logic               cfg_we;
  reg_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_SIDE:   prdata = 32'(side_q);
      REG_RADIUS: prdata = 32'(rad_q);
      REG_FILL:   prdata = {{(32 - SampleW){fill_q[SampleW-1]}}, fill_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(16);
      rad_q  <= RadW'(1);
      fill_q <= SampleW'(8192);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIDE:   side_q <= pwdata[SideW-1:0];
        REG_RADIUS: rad_q  <= pwdata[RadW-1:0];
        REG_FILL:   fill_q <= pwdata[SampleW-1:0];
        default:    ;
      endcase
    end
  end

  // effective geometry
  logic [SW-1:0] eside;
  logic [NW-1:0] nval;
  logic [NW-1:0] last;
  logic [PW-1:0] total;

  always_comb begin
    if (side_q == '0) begin
      eside = SW'(1);
    end else if (int'(side_q) > MAX_SIDE) begin
      eside = SW'(MAX_SIDE);
    end else begin
      eside = SW'(side_q);
    end
  end

  assign nval  = NW'(eside * SCALE);
  assign last  = nval - NW'(1);
  assign total = PW'(eside) * PW'(eside);

  // input fields
  logic               in_acc;
  logic               op;
  logic [SampleW-1:0] smp;
  logic               novl;
  logic [PosW-1:0]    row_in;
  logic [PosW-1:0]    col_in;

  assign op     = s_axis_tuser_i[0];
  assign smp    = s_axis_tdata_i[23:0];
  assign novl   = s_axis_tdata_i[24];
  assign row_in = s_axis_tdata_i[31:25];
  assign col_in = s_axis_tdata_i[38:32];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // memories
  logic [SampleW-1:0] src_mem [SrcDep];
  logic [SATW-1:0]    sat_mem [SatDep];
  logic               src_we;
  logic [AW-1:0]      src_waddr;
  logic [SampleW-1:0] src_wdata;
  logic [AW-1:0]      src_raddr;
  logic [SampleW-1:0] src_rd_q;
  logic               sat_we;
  logic [2*CW-1:0]    sat_waddr;
  logic [SATW-1:0]    sat_wdata;
  logic [2*CW-1:0]    sat_raddr;
  logic [SATW-1:0]    sat_rd_q;

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    src_rd_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sat_we) begin
      sat_mem[sat_waddr] <= sat_wdata;
    end
    sat_rd_q <= sat_mem[sat_raddr];
  end

  // control state
  state_e        state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          rdy_q, rdy_d;
  logic          ov_q, ov_d;

  // build counters
  logic [CW-1:0]   by_q, by_d, bx_q, bx_d;
  logic [SBW-1:0]  ys_q, ys_d, xs_q, xs_d;
  logic [AW-1:0]   rb_q, rb_d, cx_q, cx_d;
  logic [SATW-1:0] racc_q, racc_d;

  // query registers
  logic [CW-1:0]   tp_q, tp_d, bt_q, bt_d, lp_q, lp_d, rt_q, rt_d;
  logic [4:0]      h_q, h_d, w_q, w_d;
  logic [2:0]      t_q, t_d;
  logic            pz_q, pz_d, pn_q, pn_d, pv_q, pv_d;
  logic [SATW-1:0] sum_q, sum_d;
  logic            neg_q, neg_d;
  logic [SampleW-1:0] rv_q, rv_d, ovl_q, ovl_d;
  status_e         rs_q, rs_d, os_q, os_d;

  // divider
  logic            div_start;
  logic            div_done;
  logic [DivW-1:0] div_quot;
  logic [DivW-1:0] dvd;
  logic [CntW-1:0] cnt;
  logic [SATW-1:0] mag;
  logic [SampleW-1:0] qv;

  assign cnt = CntW'(h_q) * CntW'(w_q);
  assign mag = sum_q[SATW-1] ? SATW'(-sum_q) : sum_q;
  assign dvd = (DivW'(mag) << 1) + DivW'(cnt);
  assign qv  = div_quot[SampleW-1:0];

  upbi_div #(
    .DW(DivW),
    .VW(VW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dvd),
    .divisor_i ({cnt, 1'b0}),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // query window, worked out at request time
  logic [QW-1:0] row_x, col_x, r_x, last_x, n_x;
  logic [QW-1:0] tp_x, bt_x, lp_x, rt_x, bsum, rsum;

  assign row_x  = QW'(row_in);
  assign col_x  = QW'(col_in);
  assign r_x    = QW'(rad_q);
  assign last_x = QW'(last);
  assign n_x    = QW'(nval);
  assign bsum   = row_x + r_x;
  assign rsum   = col_x + r_x;
  assign tp_x   = (row_x >= r_x) ? row_x - r_x : '0;
  assign lp_x   = (col_x >= r_x) ? col_x - r_x : '0;
  assign bt_x   = (bsum > last_x) ? last_x : bsum;
  assign rt_x   = (rsum > last_x) ? last_x : rsum;

  // load position
  logic [PW-1:0] pos_base, pos_inc;

  always_comb begin
    pos_base = rdy_q ? '0 : pos_q;
    if (pos_base >= total) begin
      pos_base = '0;
    end
    pos_inc = pos_base + PW'(1);
  end

  assign src_we    = (state_q == ST_IDLE) && in_acc && !op;
  assign src_waddr = pos_base[AW-1:0];
  assign src_wdata = novl ? fill_q : smp;
  assign src_raddr = rb_q + cx_q;

  // build datapath
  logic [SATW-1:0] row_sum;

  assign row_sum   = ((bx_q == '0) ? '0 : racc_q)
                   + {{(SATW - SampleW){src_rd_q[SampleW-1]}}, src_rd_q};
  assign sat_we    = (state_q == ST_BWR);
  assign sat_waddr = {by_q, bx_q};
  assign sat_wdata = ((by_q == '0) ? '0 : sat_rd_q) + row_sum;

  // corner terms: bottom-right +, top-right -, bottom-left -, top-left +
  logic [CW-1:0] trow, tcol;

  assign trow = t_q[0] ? tp_q - CW'(1) : bt_q;
  assign tcol = t_q[1] ? lp_q - CW'(1) : rt_q;

  always_comb begin
    if (state_q == ST_QRD) begin
      sat_raddr = {trow, tcol};
    end else begin
      sat_raddr = {by_q - CW'(1), bx_q};
    end
  end

  logic out_free;
  assign out_free = !ov_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    rdy_d     = rdy_q;
    by_d      = by_q;
    bx_d      = bx_q;
    ys_d      = ys_q;
    xs_d      = xs_q;
    rb_d      = rb_q;
    cx_d      = cx_q;
    racc_d    = racc_q;
    tp_d      = tp_q;
    bt_d      = bt_q;
    lp_d      = lp_q;
    rt_d      = rt_q;
    h_d       = h_q;
    w_d       = w_q;
    t_d       = t_q;
    pz_d      = pz_q;
    pn_d      = pn_q;
    pv_d      = 1'b0;
    sum_d     = sum_q;
    neg_d     = neg_q;
    rv_d      = rv_q;
    rs_d      = rs_q;
    ov_d      = ov_q;
    ovl_d     = ovl_q;
    os_d      = os_q;
    div_start = 1'b0;
    s_axis_tready_o = (state_q == ST_IDLE);

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && !op) begin
          rdy_d = 1'b0;
          if (pos_inc >= total) begin
            pos_d   = '0;
            by_d    = '0;
            bx_d    = '0;
            ys_d    = '0;
            xs_d    = '0;
            rb_d    = '0;
            cx_d    = '0;
            state_d = ST_BRD;
          end else begin
            pos_d = pos_inc;
          end
        end else if (in_acc) begin
          rv_d = '0;
          if (!rdy_q) begin
            rs_d    = STAT_EMPTY;
            state_d = ST_OUT;
          end else if (row_x >= n_x || col_x >= n_x) begin
            rs_d    = STAT_RANGE;
            state_d = ST_OUT;
          end else begin
            tp_d    = CW'(tp_x);
            bt_d    = CW'(bt_x);
            lp_d    = CW'(lp_x);
            rt_d    = CW'(rt_x);
            h_d     = 5'(bt_x - tp_x + QW'(1));
            w_d     = 5'(rt_x - lp_x + QW'(1));
            t_d     = '0;
            sum_d   = '0;
            state_d = ST_QRD;
          end
        end
      end
      ST_BRD: begin
        state_d = ST_BWR;
      end
      ST_BWR: begin
        racc_d = row_sum;
        if (NW'(bx_q) == last) begin
          bx_d = '0;
          xs_d = '0;
          cx_d = '0;
          if (NW'(by_q) == last) begin
            rdy_d   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            by_d    = by_q + CW'(1);
            state_d = ST_BRD;
            if (int'(ys_q) == SCALE - 1) begin
              ys_d = '0;
              rb_d = rb_q + AW'(eside);
            end else begin
              ys_d = ys_q + SBW'(1);
            end
          end
        end else begin
          bx_d    = bx_q + CW'(1);
          state_d = ST_BRD;
          if (int'(xs_q) == SCALE - 1) begin
            xs_d = '0;
            cx_d = cx_q + AW'(1);
          end else begin
            xs_d = xs_q + SBW'(1);
          end
        end
      end
      ST_QRD: begin
        // issue one corner a cycle, add the one read the cycle before
        t_d = t_q + 3'd1;
        if (t_q < 3'd4) begin
          pv_d = 1'b1;
          pz_d = (t_q[0] && tp_q == '0) || (t_q[1] && lp_q == '0);
          pn_d = t_q[0] ^ t_q[1];
        end
        if (pv_q && !pz_q) begin
          sum_d = pn_q ? sum_q - sat_rd_q : sum_q + sat_rd_q;
        end
        if (t_q == 3'd5) begin
          div_start = 1'b1;
          neg_d     = sum_q[SATW-1];
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          rv_d    = neg_q ? SampleW'(-qv) : qv;
          rs_d    = STAT_OK;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ovl_d   = rv_q;
          os_d    = rs_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // patch side rewrite restarts loading
    if (cfg_we && cfg_idx == REG_SIDE) begin
      pos_d = '0;
      rdy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      rdy_q   <= 1'b0;
      ov_q    <= 1'b0;
      pv_q    <= 1'b0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rdy_q   <= rdy_d;
      ov_q    <= ov_d;
      pv_q    <= pv_d;
      t_q     <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    by_q   <= by_d;
    bx_q   <= bx_d;
    ys_q   <= ys_d;
    xs_q   <= xs_d;
    rb_q   <= rb_d;
    cx_q   <= cx_d;
    racc_q <= racc_d;
    tp_q   <= tp_d;
    bt_q   <= bt_d;
    lp_q   <= lp_d;
    rt_q   <= rt_d;
    h_q    <= h_d;
    w_q    <= w_d;
    pz_q   <= pz_d;
    pn_q   <= pn_d;
    sum_q  <= sum_d;
    neg_q  <= neg_d;
    rv_q   <= rv_d;
    rs_q   <= rs_d;
    ovl_q  <= ovl_d;
    os_q   <= os_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {6'b0, os_q, ovl_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[25:24] != STAT_OK) |-> m_axis_tdata_o[23:0] == '0)
    else $error("nonzero value with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BRD || state_q == ST_BWR) |-> !rdy_q)
    else $error("table marked ready during build");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider result outside divide state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !op && !cfg_we) |=> !rdy_q)
    else $error("table ready right after a load");

endmodule

### rtl/core/upbi_div.sv
module upbi_div #(
  parameter int DW = 36,
  parameter int VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] acc_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;
  logic [KW-1:0] cnt_q;
  logic          done_q;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, acc_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == KW'(1));
      if (start_i) begin
        cnt_q <= KW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - KW'(1);
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? VW'(trial - {1'b0, div_q}) : VW'(trial);
      acc_q <= {acc_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> cnt_q == '0)
    else $error("divider done while still iterating");

endmodule

### sim/tb_upsample_box_blur_integral.sv
module tb_upsample_box_blur_integral;
  timeunit 1ns;
  timeprecision 1ps;

  import upbi_pkg::*;

  localparam int TblW = 128;

  typedef struct packed {
    logic [23:0] value;
    status_e     status;
  } blur_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block state
  logic [6:0]         side_reg;
  logic [3:0]         radius_reg;
  logic signed [23:0] fill_reg;
  logic signed [23:0] src_pix [0:4095];
  longint             area_sum [0:TblW*TblW-1];
  int                 load_pos;
  bit                 sums_ready;

  blur_result_t mean_queue[$];
  int           errors = 0;
  int           items_sent = 0;
  bit           steady = 1'b0;

  upsample_box_blur_integral u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 22);
  endfunction

  function automatic int side_now();
    if (side_reg == 0) return 1;
    if (side_reg > 64) return 64;
    return side_reg;
  endfunction

  function automatic longint sum_at(int y, int x);
    if (y < 0 || x < 0) return 0;
    return area_sum[y*TblW + x];
  endfunction

  task automatic build_area_sums(int side);
    int n;
    n = side * ScaleDef;
    for (int y = 0; y < n; y++)
      for (int x = 0; x < n; x++)
        area_sum[y*TblW + x] = longint'(src_pix[(y/ScaleDef)*side + x/ScaleDef])
          + sum_at(y, x-1) + sum_at(y-1, x) - sum_at(y-1, x-1);
  endtask

  function automatic blur_result_t box_mean(int row, int col);
    blur_result_t res;
    int last, top, bottom, left, right;
    longint sum, mag, cnt;
    res.value = '0;
    res.status = STAT_OK;
    last = side_now() * ScaleDef - 1;
    if (!sums_ready) begin
      res.status = STAT_EMPTY;
      return res;
    end
    if (row > last || col > last) begin
      res.status = STAT_RANGE;
      return res;
    end
    top = row - radius_reg - 1;
    if (top < -1) top = -1;
    bottom = row + radius_reg;
    if (bottom > last) bottom = last;
    left = col - radius_reg - 1;
    if (left < -1) left = -1;
    right = col + radius_reg;
    if (right > last) right = last;
    cnt = longint'(right - left) * longint'(bottom - top);
    sum = sum_at(bottom, right) - sum_at(top, right) - sum_at(bottom, left)
        + sum_at(top, left);
    mag = (sum < 0) ? -sum : sum;
    mag = (2*mag + cnt) / (2*cnt);
    res.value = 24'((sum < 0) ? -mag : mag);
    return res;
  endfunction

  // queue the expected result of one query
  task automatic enqueue_mean(blur_result_t res);
    mean_queue = {mean_queue, res};
  endtask

  // advance the shadow state for one accepted request
  task automatic apply_request(bit op, logic [23:0] smp, bit nv, int row, int col);
    int side;
    side = side_now();
    if (op == 1'b0) begin
      if (sums_ready) begin
        sums_ready = 1'b0;
        load_pos = 0;
      end
      if (load_pos >= side*side) load_pos = 0;
      src_pix[load_pos] = nv ? fill_reg : smp;
      load_pos++;
      if (load_pos >= side*side) begin
        load_pos = 0;
        build_area_sums(side);
        sums_ready = 1'b1;
      end
    end else begin
      enqueue_mean(box_mean(row, col));
    end
  endtask

  task automatic send_request(bit op, logic [23:0] smp, bit nv, int row, int col);
    @(negedge clk_i);
    while (take_gap()) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tdata = {1'b0, 7'(col), 7'(row), nv, smp};
    s_tuser = op;
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    apply_request(op, smp, nv, row, col);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (mean_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    // a load may have started the table pass
    while (!s_tready) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    s_tvalid = 1'b0;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 4'(4 * idx);
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_SIDE: begin
        side_reg = data[6:0];
        load_pos = 0;
        sums_ready = 1'b0;
      end
      REG_RADIUS: radius_reg = data[3:0];
      REG_FILL:   fill_reg = data[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
  endtask

  always @(negedge clk_i) m_tready <= steady || ($urandom_range(99) >= 22);

  always @(posedge clk_i) begin
    blur_result_t exp;
    if (rst_ni && m_tvalid && m_tready) begin
      if (mean_queue.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        exp = mean_queue.pop_front();
        if (m_tdata[25:24] != exp.status)
          report_mismatch("status", m_tdata[25:24], exp.status);
        if (m_tdata[23:0] != exp.value)
          report_mismatch("value", signed'(m_tdata[23:0]), signed'(exp.value));
      end
    end
  end

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'(-$urandom_range(4096));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int pick_pos(int n);
    if ($urandom_range(9) == 0) return $urandom_range(127);
    return $urandom_range(n - 1);
  endfunction

  task automatic load_patch(int count, int query_pct);
    int n;
    for (int i = 0; i < count; i++) begin
      n = side_now() * ScaleDef;
      send_request(1'b0, pick_sample(), $urandom_range(9) == 0, $urandom_range(127),
                   $urandom_range(127));
      if ($urandom_range(99) < query_pct)
        send_request(1'b1, 24'($urandom), $urandom_range(1), pick_pos(n), pick_pos(n));
    end
  endtask

  task automatic query_some(int count);
    int n;
    n = side_now() * ScaleDef;
    for (int i = 0; i < count; i++)
      send_request(1'b1, 24'($urandom), $urandom_range(1), pick_pos(n), pick_pos(n));
  endtask

  task automatic test_reset_side_and_single();
    send_request(1'b1, 24'h0, 1'b0, 0, 0);
    wait_idle();
    write_reg(REG_SIDE, 32'd0);
    send_request(1'b0, 24'h7fffff, 1'b0, 0, 0);
    send_request(1'b1, 24'h0, 1'b0, 1, 1);
    send_request(1'b1, 24'h0, 1'b0, 2, 0);
    send_request(1'b1, 24'h0, 1'b0, 127, 127);
    wait_idle();
    write_reg(REG_SIDE, 32'd127);
    send_request(1'b1, 24'h0, 1'b0, 127, 127);
    wait_idle();
  endtask

  task automatic test_small_extremes();
    write_reg(REG_SIDE, 32'd2);
    write_reg(REG_FILL, 32'hff800000);
    write_reg(REG_RADIUS, 32'd0);
    send_request(1'b0, 24'h800000, 1'b0, 0, 0);
    send_request(1'b0, 24'h7fffff, 1'b0, 0, 0);
    send_request(1'b0, 24'h7fffff, 1'b1, 0, 0);
    send_request(1'b0, 24'h000001, 1'b0, 127, 127);
    send_request(1'b1, 24'hffffff, 1'b1, 0, 0);
    send_request(1'b1, 24'h0, 1'b0, 3, 3);
    send_request(1'b1, 24'h0, 1'b0, 4, 0);
    wait_idle();
    write_reg(REG_RADIUS, 32'd15);
    write_reg(REG_FILL, 32'h007fffff);
    send_request(1'b1, 24'h0, 1'b0, 1, 2);
    // a load after a full patch restarts it
    send_request(1'b0, 24'h0, 1'b1, 0, 0);
    send_request(1'b1, 24'h0, 1'b0, 0, 0);
    wait_idle();
  endtask

  task automatic test_wide_patch();
    write_reg(REG_SIDE, 32'd32);
    write_reg(REG_RADIUS, 32'd15);
    load_patch(32*32, 0);
    send_request(1'b1, 24'h0, 1'b0, 0, 0);
    send_request(1'b1, 24'h0, 1'b0, 63, 63);
    send_request(1'b1, 24'h0, 1'b0, 64, 63);
    query_some(6);
    wait_idle();
  endtask

  task automatic test_random_patches();
    int side;
    while (items_sent < 1800) begin
      steady = ($urandom_range(9) == 0);
      side = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      if ($urandom_range(3) != 0) write_reg(REG_SIDE, side);
      write_reg(REG_RADIUS, $urandom_range(3) == 0 ? 15 * $urandom_range(1) :
                $urandom_range(15));
      if ($urandom_range(2) == 0) write_reg(REG_FILL, 32'($urandom));
      side = side_now();
      if ($urandom_range(7) == 0) begin
        // broken patch, cut short by a side rewrite
        load_patch($urandom_range(side*side), 10);
        wait_idle();
        write_reg(REG_SIDE, 32'(side_reg));
      end
      load_patch(side*side, 3);
      query_some($urandom_range(3, 12));
      wait_idle();
      write_reg(REG_RADIUS, $urandom_range(15));
      query_some($urandom_range(1, 6));
      wait_idle();
    end
    steady = 1'b0;
  endtask

  initial begin
    side_reg = 7'd16;
    radius_reg = 4'd1;
    fill_reg = 24'sd8192;
    load_pos = 0;
    sums_ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_side_and_single();
    test_small_extremes();
    test_wide_patch();
    test_random_patches();
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && mean_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
